### hdl/imufd_pkg.sv
// imufd_pkg: shared types and constants for the IMU frame checksum decoder.
// No dependencies; imported by every other file of the block.
package imufd_pkg;

    localparam int BODY_BYTES     = 10;
    localparam int PAYLOAD_BYTES  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;

    localparam int AXIS_W = 20;
    localparam int TEMP_W = 17;

    // temperature: floor((128*raw + 85) / 170) + 9280, divided by reciprocal
    localparam int          TEMP_DIV     = 170;
    localparam logic [24:0] TEMP_BIAS    = 25'd4194665;   // 85 + 170*24674
    localparam logic [24:0] TEMP_RECIP   = 25'd25264513;  // floor(2^32 / 170)
    localparam logic [16:0] TEMP_OFFSET  = 17'd15394;     // 24674 - 9280

    typedef enum logic [1:0] {
        KIND_ACCEL   = 2'd0,
        KIND_RATE    = 2'd1,
        KIND_ANGLE   = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef struct packed {
        logic               sum_ok;
        kind_t              kind;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_t;
    } imufd_frame_t;

endpackage

### hdl/imufd_if.sv
// imufd_if: valid/ready channel interfaces for the byte input and the result output.
// Depends on imufd_pkg for field widths.
interface imufd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufd_result_if
    import imufd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     sum_ok;
    logic [1:0]               frame_kind;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output sum_ok, output frame_kind, output axis_x,
                    output axis_y, output axis_z, output temperature, input ready);
    modport sink   (input valid, input sum_ok, input frame_kind, input axis_x,
                    input axis_y, input axis_z, input temperature, output ready);
endinterface

### hdl/imufd_front.sv
// imufd_front: byte parser; hunts the header, sums the frame, collects payload.
// Depends on imufd_pkg. Pushes one frame record per checksum byte.
module imufd_front
    import imufd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    output logic         in_ready,
    input  logic         q_full,
    output logic         push,
    output imufd_frame_t push_frame
);

    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  payload_reg [PAYLOAD_BYTES];
    logic        accept;
    logic        pay_we;
    logic [2:0]  pay_addr;
    logic [3:0]  idx_off;
    kind_t       kind;

    assign in_ready = !((idx_reg == 4'(BODY_BYTES)) && q_full);
    assign accept   = in_valid && in_ready;
    assign idx_off  = idx_reg - 4'd2;
    assign pay_addr = idx_off[2:0];

    always_comb
    begin
        unique case (type_reg)
            TYPE_ACCEL: kind = KIND_ACCEL;
            TYPE_RATE:  kind = KIND_RATE;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:    kind = KIND_UNKNOWN;
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        type_next = type_reg;
        pay_we    = 1'b0;
        push      = 1'b0;
        if (accept)
        begin
            if (idx_reg == 4'd0)
            begin
                if (in_byte == HEADER_BYTE)
                begin
                    sum_next = in_byte;
                    idx_next = 4'd1;
                end
            end
            else if (idx_reg == 4'd1)
            begin
                type_next = in_byte;
                sum_next  = sum_reg + in_byte;
                idx_next  = 4'd2;
            end
            else if (idx_reg < 4'(BODY_BYTES))
            begin
                pay_we   = 1'b1;
                sum_next = sum_reg + in_byte;
                idx_next = idx_reg + 4'd1;
            end
            else
            begin
                push     = 1'b1;
                idx_next = 4'd0;
            end
        end
    end

    assign push_frame.sum_ok = (sum_reg == in_byte);
    assign push_frame.kind   = kind;
    assign push_frame.raw_x  = {payload_reg[1], payload_reg[0]};
    assign push_frame.raw_y  = {payload_reg[3], payload_reg[2]};
    assign push_frame.raw_z  = {payload_reg[5], payload_reg[4]};
    assign push_frame.raw_t  = {payload_reg[7], payload_reg[6]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 4'd0;
            sum_reg  <= 8'd0;
            type_reg <= 8'd0;
        end
        else
        begin
            idx_reg  <= idx_next;
            sum_reg  <= sum_next;
            type_reg <= type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_reg[pay_addr] <= in_byte;
        end
    end

endmodule

### hdl/imufd_queue.sv
// imufd_queue: small FIFO of frame records between parser and scaler.
// Depends on imufd_pkg for the record type.
module imufd_queue
    import imufd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  imufd_frame_t push_frame,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output imufd_frame_t head_frame
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    imufd_frame_t    mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_frame = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### hdl/imufd_back.sv
// imufd_back: three-stage scaler from raw words to Q.8 results, with output register.
// Depends on imufd_pkg. Whole pipe holds while the output item is stalled.
module imufd_back
    import imufd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  imufd_frame_t             head_frame,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_sum_ok,
    output logic [1:0]               out_kind,
    output logic signed [AXIS_W-1:0] out_x,
    output logic signed [AXIS_W-1:0] out_y,
    output logic signed [AXIS_W-1:0] out_z,
    output logic signed [TEMP_W-1:0] out_temp
);

    logic en;

    // stage 1: kind-dependent product plus rounding bias, temperature numerator
    logic               s1_valid_reg;
    logic               s1_sum_ok_reg;
    kind_t              s1_kind_reg;
    logic signed [24:0] s1_p_reg [3];
    logic [23:0]        s1_m_reg;

    // stage 2: rounded axes, reciprocal quotient estimate
    logic                     s2_valid_reg;
    logic                     s2_sum_ok_reg;
    kind_t                    s2_kind_reg;
    logic signed [AXIS_W-1:0] s2_axis_reg [3];
    logic [23:0]              s2_m_reg;
    logic [15:0]              s2_q_reg;

    // output register
    logic                     out_valid_reg;
    logic                     out_sum_ok_reg;
    kind_t                    out_kind_reg;
    logic signed [AXIS_W-1:0] out_axis_reg [3];
    logic signed [TEMP_W-1:0] out_temp_reg;

    logic signed [15:0] raw [3];
    logic signed [24:0] p_next [3];
    logic signed [24:0] m_wide;
    logic signed [24:0] raw_t_ext;
    logic [48:0]        q_prod;
    logic [23:0]        q_times_div;
    logic [23:0]        rem;
    logic [15:0]        q_fix;
    logic signed [TEMP_W-1:0] temp_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = head_valid && en;

    assign raw[0] = head_frame.raw_x;
    assign raw[1] = head_frame.raw_y;
    assign raw[2] = head_frame.raw_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (head_frame.kind)
                KIND_ACCEL: p_next[i] = 25'(raw[i]) + 25'sd4;
                KIND_RATE:  p_next[i] = 25'(raw[i]) * 25'sd125 + 25'sd4;
                KIND_ANGLE: p_next[i] = 25'(raw[i]) * 25'sd45 + 25'sd16;
                default:    p_next[i] = '0;
            endcase
        end
    end

    assign raw_t_ext = 25'(head_frame.raw_t);
    assign m_wide    = (raw_t_ext <<< 7) + $signed(TEMP_BIAS);

    assign q_prod      = 49'(s1_m_reg) * 49'(TEMP_RECIP);
    assign q_times_div = 24'(s2_q_reg) * 24'(TEMP_DIV);
    assign rem         = s2_m_reg - q_times_div;
    assign q_fix       = (rem >= 24'(TEMP_DIV)) ? s2_q_reg + 16'd1 : s2_q_reg;
    assign temp_next   = $signed({1'b0, q_fix} - TEMP_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sum_ok_reg <= head_frame.sum_ok;
            s1_kind_reg   <= head_frame.kind;
            s1_m_reg      <= m_wide[23:0];
            for (int i = 0; i < 3; i++)
            begin
                s1_p_reg[i] <= p_next[i];
            end

            s2_sum_ok_reg <= s1_sum_ok_reg;
            s2_kind_reg   <= s1_kind_reg;
            s2_m_reg      <= s1_m_reg;
            s2_q_reg      <= q_prod[47:32];
            for (int i = 0; i < 3; i++)
            begin
                unique case (s1_kind_reg) inside
                    KIND_ACCEL, KIND_RATE: s2_axis_reg[i] <= AXIS_W'(s1_p_reg[i] >>> 3);
                    KIND_ANGLE:            s2_axis_reg[i] <= AXIS_W'(s1_p_reg[i] >>> 5);
                    default:               s2_axis_reg[i] <= '0;
                endcase
            end

            out_sum_ok_reg <= s2_sum_ok_reg;
            out_kind_reg   <= s2_kind_reg;
            out_temp_reg   <= temp_next;
            for (int i = 0; i < 3; i++)
            begin
                out_axis_reg[i] <= s2_axis_reg[i];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sum_ok = out_sum_ok_reg;
    assign out_kind   = out_kind_reg;
    assign out_x      = out_axis_reg[0];
    assign out_y      = out_axis_reg[1];
    assign out_z      = out_axis_reg[2];
    assign out_temp   = out_temp_reg;

endmodule

### hdl/imu_frame_checksum_decoder_core.sv
// imu_frame_checksum_decoder_core: top level of the IMU serial frame decoder.
// Depends on imufd_pkg, imufd_if, imufd_front, imufd_queue, imufd_back.
//
//   channel  dir  payload                                          accepted when
//   rx       in   rx_byte[7:0]                                     valid && ready
//   result   out  sum_ok, frame_kind, axis_x/y/z[19:0], temp[16:0] valid && ready
//
// One byte per cycle while rx.ready is high. A result passes through the queue, product
// stage, reciprocal stage and output register after its checksum byte is taken.
// Reset clears the parser, queue pointers and pipeline valids; payload bytes are not reset.
// rx.ready drops only on a checksum byte while the frame queue is full.
module imu_frame_checksum_decoder_core
    import imufd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    imufd_byte_if.sink    rx,
    imufd_result_if.source result
);

    logic         q_full;
    logic         push;
    imufd_frame_t push_frame;
    logic         pop;
    logic         head_valid;
    imufd_frame_t head_frame;

    imufd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_byte    (rx.rx_byte),
        .in_ready   (rx.ready),
        .q_full     (q_full),
        .push       (push),
        .push_frame (push_frame)
    );

    imufd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    imufd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_sum_ok (result.sum_ok),
        .out_kind   (result.frame_kind),
        .out_x      (result.axis_x),
        .out_y      (result.axis_y),
        .out_z      (result.axis_z),
        .out_temp   (result.temperature)
    );

endmodule

### hdl/imufd_checker.sv
// imufd_checker: port-level assertions for imu_frame_checksum_decoder_core.
// Depends on imufd_pkg; bound to the top level at the end of this file.
module imufd_checker
    import imufd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic                     sum_ok,
    input logic [1:0]               frame_kind,
    input logic signed [AXIS_W-1:0] axis_x,
    input logic signed [AXIS_W-1:0] axis_y,
    input logic signed [AXIS_W-1:0] axis_z,
    input logic signed [TEMP_W-1:0] temperature
);

    localparam logic signed [AXIS_W-1:0] ACCEL_MAX = 20'sd4096;
    localparam logic signed [AXIS_W-1:0] ACCEL_MIN = -20'sd4096;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 17'sd33952;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = -17'sd15392;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(sum_ok) && $stable(frame_kind)
            && $stable(axis_x) && $stable(temperature))
        else $error("result changed while stalled");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (frame_kind == KIND_UNKNOWN) |-> (axis_x == '0) && (axis_y == '0)
            && (axis_z == '0))
        else $error("unknown frame with nonzero axes");

    a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (frame_kind == KIND_ACCEL) |->
            (axis_x >= ACCEL_MIN) && (axis_x <= ACCEL_MAX) &&
            (axis_y >= ACCEL_MIN) && (axis_y <= ACCEL_MAX) &&
            (axis_z >= ACCEL_MIN) && (axis_z <= ACCEL_MAX))
        else $error("acceleration out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (temperature >= TEMP_MIN) && (temperature <= TEMP_MAX))
        else $error("temperature out of range");

endmodule

bind imu_frame_checksum_decoder_core imufd_checker u_imufd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .sum_ok      (result.sum_ok),
    .frame_kind  (result.frame_kind),
    .axis_x      (result.axis_x),
    .axis_y      (result.axis_y),
    .axis_z      (result.axis_z),
    .temperature (result.temperature)
);

### tb/sv/imu_frame_checksum_decoder_core_tb.sv
// imu_frame_checksum_decoder_core_tb: self-checking bench for the IMU frame decoder.
// Depends on imufd_pkg, imufd_if and imu_frame_checksum_decoder_core; predicts each
// decoded frame from the byte stream and checks every result item in order.
module imu_frame_checksum_decoder_core_tb
    import imufd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              sum_ok;
        kind_t             kind;
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
        logic [AXIS_W-1:0] z;
        logic [TEMP_W-1:0] temp;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n;

    imufd_byte_if   rx_if();
    imufd_result_if res_if();

    imu_frame_checksum_decoder_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    always #1 clk = ~clk;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;

    // frame tracker state
    logic [3:0] frame_pos = '0;
    logic [7:0] frame_sum = '0;
    logic [7:0] frame_type = '0;
    logic [7:0] frame_body [PAYLOAD_BYTES];

    frame_result_t pending_frames[$];

    // round n/d to nearest, ties toward +inf, d > 0
    function automatic longint round_half_up(input longint n, input longint d);
        longint t;
        longint b;
        longint q;
        t = 2 * n + d;
        b = 2 * d;
        q = t / b;
        if ((t % b != 0) && (t < 0))
            q = q - 1;
        return q;
    endfunction

    function automatic int body_word(input int i);
        logic [15:0] w;
        w = {frame_body[3'(2*i+1)], frame_body[3'(2*i)]};
        return int'($signed(w));
    endfunction

    function automatic logic [AXIS_W-1:0] axis_q8(input int raw, input kind_t k);
        longint v;
        case (k)
            KIND_ACCEL: v = round_half_up(raw, 8);
            KIND_RATE:  v = round_half_up(longint'(raw) * 125, 8);
            KIND_ANGLE: v = round_half_up(longint'(raw) * 45, 32);
            default:    v = 0;
        endcase
        return v[AXIS_W-1:0];
    endfunction

    task automatic track_byte(input logic [7:0] b);
        frame_result_t r;
        longint tv;
        if (frame_pos == 4'd0)
        begin
            if (b == HEADER_BYTE)
            begin
                frame_sum = b;
                frame_pos = 4'd1;
            end
        end
        else if (frame_pos == 4'd1)
        begin
            frame_type = b;
            frame_sum  = frame_sum + b;
            frame_pos  = 4'd2;
        end
        else if (frame_pos < 4'(BODY_BYTES))
        begin
            frame_body[3'(frame_pos - 4'd2)] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            frame_pos = 4'd0;
            case (frame_type)
                TYPE_ACCEL: r.kind = KIND_ACCEL;
                TYPE_RATE:  r.kind = KIND_RATE;
                TYPE_ANGLE: r.kind = KIND_ANGLE;
                default:    r.kind = KIND_UNKNOWN;
            endcase
            r.sum_ok = (frame_sum == b);
            r.x      = axis_q8(body_word(0), r.kind);
            r.y      = axis_q8(body_word(1), r.kind);
            r.z      = axis_q8(body_word(2), r.kind);
            tv       = round_half_up(longint'(body_word(3)) * 64, 85) + 9280;
            r.temp   = tv[TEMP_W-1:0];
            pending_frames.push_back(r);
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        track_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] wx,
                              input logic [15:0] wy, input logic [15:0] wz,
                              input logic [15:0] wt, input bit bad_sum);
        logic [7:0] fb [BODY_BYTES+1];
        logic [7:0] s;
        int i;
        fb = '{HEADER_BYTE, ftype, wx[7:0], wx[15:8], wy[7:0], wy[15:8],
               wz[7:0], wz[15:8], wt[7:0], wt[15:8], 8'h00};
        s = '0;
        for (i = 0; i < BODY_BYTES; i++)
            s = s + fb[i];
        fb[BODY_BYTES] = bad_sum ? s + 8'($urandom_range(255, 1)) : s;
        for (i = 0; i <= BODY_BYTES; i++)
            send_byte(fb[i]);
    endtask

    task automatic wait_drain();
        rx_if.valid <= 1'b0;
        do @(negedge clk); while (pending_frames.size() != 0);
    endtask

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h8000;
        else if (r < 20)
            return 16'h7FFF;
        else if (r < 35)
            return 16'($signed($urandom_range(32)) - 16);
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_type();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return TYPE_ACCEL;
        else if (r < 60)
            return TYPE_RATE;
        else if (r < 90)
            return TYPE_ANGLE;
        return 8'($urandom);
    endfunction

    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h54);
        send_byte(8'hAA);
    endtask

    task automatic test_accel_extremes();
        send_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFC, 16'h8000, 1'b0);
    endtask

    task automatic test_rate_ties();
        send_frame(TYPE_RATE, 16'h0004, 16'hFFFC, 16'h7FFF, 16'h7FFF, 1'b0);
    endtask

    task automatic test_angle_bad_sum_inner_header();
        send_frame(TYPE_ANGLE, 16'h0010, 16'hFFF0, 16'h5555, 16'h0000, 1'b1);
    endtask

    task automatic test_unknown_type();
        send_frame(HEADER_BYTE, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_random_traffic(input int frames, input int idle_pct,
                                       input int stall_pct);
        int n;
        int r;
        int k;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (n = 0; n < frames; n++)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
            end
            else if (r < 12)
            begin
                send_byte(HEADER_BYTE);
                k = $urandom_range(9, 1);
                repeat (k) send_byte(8'($urandom));
            end
            send_frame(rand_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                       $urandom_range(99) < 15);
        end
        wait_drain();
    endtask

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item at %0t", $realtime);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (res_if.sum_ok !== want.sum_ok || res_if.frame_kind !== want.kind ||
                    res_if.axis_x !== want.x || res_if.axis_y !== want.y ||
                    res_if.axis_z !== want.z || res_if.temperature !== want.temp)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch %0t exp %0b %0d %h %h %h %h got %0b %0d %h %h %h %h",
                                 $realtime, want.sum_ok, want.kind, want.x, want.y,
                                 want.z, want.temp, res_if.sum_ok, res_if.frame_kind,
                                 res_if.axis_x, res_if.axis_y, res_if.axis_z,
                                 res_if.temperature);
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_hunt_noise();
        test_accel_extremes();
        test_rate_ties();
        test_angle_bad_sum_inner_header();
        test_unknown_type();
        wait_drain();

        test_random_traffic(20, 0, 0);
        test_random_traffic(20, 79, 0);
        test_random_traffic(20, 0, 79);
        test_random_traffic(20, 13, 13);

        repeat (12) @(negedge clk);
        fail_count += pending_frames.size();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hdl/imufd_pkg.sv
hdl/imufd_if.sv
hdl/imufd_front.sv
hdl/imufd_queue.sv
hdl/imufd_back.sv
hdl/imu_frame_checksum_decoder_core.sv
hdl/imufd_checker.sv
tb/sv/imu_frame_checksum_decoder_core_tb.sv
